// ===== rtl/tllik_pkg.sv =====
// tllik_pkg: shared widths, codes, structs and constant tables for the
// two-link leg inverse kinematics pipeline. No dependencies.
package tllik_pkg;

  // field widths
  localparam int LEG_W  = 2;
  localparam int POS_W  = 16;
  localparam int LEN_W  = 15;
  localparam int ANG_W  = 16;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 2;

  // internal widths
  localparam int N_W     = 34;  // law of cosines numerator, signed
  localparam int SQ_W    = 64;  // squared terms
  localparam int ROOT_W  = 32;  // integer square root
  localparam int CD_W    = 45;  // cordic vector coordinates, signed
  localparam int AN_W    = 24;  // angles, radians * 2^20, signed
  localparam int SUM_W   = 25;  // angle sums
  localparam int SH_W    = 6;   // normalizing shift amount
  localparam int NORM_MSB = 40; // vector is scaled until a coordinate reaches 2^40
  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS   = 32;

  localparam logic signed [AN_W-1:0] HALF_PI_Q = 24'sd1647099;
  localparam logic signed [AN_W-1:0] PI_Q      = 24'sd3294199;

  localparam logic signed [AN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
    24'sd32757, 24'sd16383, 24'sd8192, 24'sd4096, 24'sd2048,
    24'sd1024, 24'sd512, 24'sd256, 24'sd128, 24'sd64,
    24'sd32, 24'sd16, 24'sd8, 24'sd4, 24'sd2
  };

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNREACH = 2'd1,
    ST_DEGEN   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER = 2'd0,
    CFG_LOWER = 2'd1
  } cfg_idx_e;

  // sideband carried through the square root stages
  typedef struct packed {
    logic [LEG_W-1:0]        leg;
    logic                    degen;
    logic                    unreach;
    logic signed [N_W-1:0]   n;
    logic [POS_W-1:0]        gu;
    logic signed [POS_W:0]   gv;
  } sq_side_t;

  // sideband carried through the cordic stages
  typedef struct packed {
    logic [LEG_W-1:0] leg;
    logic             degen;
    logic             unreach;
    logic             n_neg;
  } cd_side_t;

  // round to nearest (ties up) into Q3.12 and saturate
  function automatic logic signed [ANG_W-1:0] angle_round(input logic signed [SUM_W-1:0] a);
    logic signed [SUM_W:0] t;
    logic signed [17:0]    q;
    logic signed [ANG_W-1:0] r;
    t = (SUM_W+1)'(a) + 26'sd128;
    q = 18'(t >>> 8);
    if (q > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (q < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = q[ANG_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/tllik_prep.sv =====
// tllik_prep: four pipeline stages forming r^2, the cosine numerator n,
// D^2 = 4 r^2 L1^2 and n^2, and the reach test. Depends on tllik_pkg.
module tllik_prep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [tllik_pkg::LEG_W-1:0]       leg_i,
  input  logic signed [tllik_pkg::POS_W-1:0] x_i,
  input  logic signed [tllik_pkg::POS_W-1:0] z_i,
  input  logic [tllik_pkg::LEN_W-1:0]       l1_i,
  input  logic [tllik_pkg::LEN_W-1:0]       l2_i,
  output logic                              valid_o,
  output tllik_pkg::sq_side_t               side_o,
  output logic [tllik_pkg::SQ_W-1:0]        rem_o
);

  // stage 1: squares
  logic                s1_valid_q;
  logic [1:0]          s1_leg_q;
  logic signed [15:0]  s1_x_q, s1_z_q;
  logic [30:0]         s1_xx_q, s1_zz_q;
  logic [29:0]         s1_l1sq_q, s1_l2sq_q;
  logic                s1_degen_q;
  logic signed [31:0]  xx_full, zz_full;
  logic [29:0]         l1sq_d, l2sq_d;

  assign xx_full = x_i * x_i;
  assign zz_full = z_i * z_i;
  assign l1sq_d  = l1_i * l1_i;
  assign l2sq_d  = l2_i * l2_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_leg_q   <= leg_i;
      s1_x_q     <= x_i;
      s1_z_q     <= z_i;
      s1_xx_q    <= xx_full[30:0];
      s1_zz_q    <= zz_full[30:0];
      s1_l1sq_q  <= l1sq_d;
      s1_l2sq_q  <= l2sq_d;
      s1_degen_q <= (z_i == '0) || (l1_i == '0);
    end
  end

  // stage 2: r^2 and numerator
  logic                s2_valid_q;
  tllik_pkg::sq_side_t s2_side_q, s2_side_d;
  logic [31:0]         s2_r2_q, r2_d;
  logic [29:0]         s2_l1sq_q;

  assign r2_d = {1'b0, s1_xx_q} + {1'b0, s1_zz_q};

  always_comb begin
    s2_side_d.leg     = s1_leg_q;
    s2_side_d.degen   = s1_degen_q;
    s2_side_d.unreach = 1'b0;
    s2_side_d.n       = $signed({4'b0, s1_l1sq_q}) + $signed({2'b0, r2_d})
                        - $signed({4'b0, s1_l2sq_q});
    s2_side_d.gu      = s1_z_q[15] ? 16'(-s1_z_q) : 16'(s1_z_q);
    s2_side_d.gv      = s1_z_q[15] ? {s1_x_q[15], s1_x_q} : -{s1_x_q[15], s1_x_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_side_q <= s2_side_d;
      s2_r2_q   <= r2_d;
      s2_l1sq_q <= s1_l1sq_q;
    end
  end

  // stage 3: D^2 and n^2
  logic                s3_valid_q;
  tllik_pkg::sq_side_t s3_side_q;
  logic [63:0]         s3_d2_q, s3_n2_q, n2_d;
  logic [61:0]         d2_prod;
  logic [33:0]         an_full;
  logic [31:0]         an;

  assign d2_prod = s2_r2_q * s2_l1sq_q;
  assign an_full = s2_side_q.n[33] ? 34'(-s2_side_q.n) : 34'(s2_side_q.n);
  assign an      = an_full[31:0];
  assign n2_d    = an * an;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_side_q <= s2_side_q;
      s3_d2_q   <= {d2_prod, 2'b00};
      s3_n2_q   <= n2_d;
    end
  end

  // stage 4: reach test and radicand
  logic                s4_valid_q;
  tllik_pkg::sq_side_t s4_side_q, s4_side_d;
  logic [63:0]         s4_rem_q;

  always_comb begin
    s4_side_d         = s3_side_q;
    s4_side_d.unreach = s3_n2_q > s3_d2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_side_q <= s4_side_d;
      s4_rem_q  <= s3_d2_q - s3_n2_q;
    end
  end

  assign valid_o = s4_valid_q;
  assign side_o  = s4_side_q;
  assign rem_o   = s4_rem_q;

endmodule

// ===== rtl/tllik_isqrt.sv =====
// tllik_isqrt: 64-bit integer square root, one result bit per pipeline
// stage (32 stages). Depends on tllik_pkg.
module tllik_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  tllik_pkg::sq_side_t          side_i,
  input  logic [tllik_pkg::SQ_W-1:0]   rem_i,
  output logic                         valid_o,
  output tllik_pkg::sq_side_t          side_o,
  output logic [tllik_pkg::ROOT_W-1:0] root_o
);

  localparam int NS = tllik_pkg::SQRT_STEPS;

  logic                        val_q  [NS];
  tllik_pkg::sq_side_t         side_q [NS];
  logic [tllik_pkg::SQ_W-1:0]  v_q    [NS];
  logic [tllik_pkg::SQ_W-1:0]  r_q    [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [tllik_pkg::SQ_W-1:0] Bit = 64'h1 << (62 - 2 * k);
    logic                        val_in;
    tllik_pkg::sq_side_t         side_in;
    logic [tllik_pkg::SQ_W-1:0]  v_in, r_in, t, v_d, r_d;

    if (k == 0) begin : g_first
      assign val_in  = valid_i;
      assign side_in = side_i;
      assign v_in    = rem_i;
      assign r_in    = '0;
    end else begin : g_next
      assign val_in  = val_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
      assign r_in    = r_q[k-1];
    end

    // restoring step for one root bit
    always_comb begin
      t = r_in + Bit;
      if (v_in >= t) begin
        v_d = v_in - t;
        r_d = (r_in >> 1) + Bit;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[k] <= 1'b0;
      end else if (en_i) begin
        val_q[k] <= val_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        v_q[k]    <= v_d;
        r_q[k]    <= r_d;
      end
    end
  end

  assign valid_o = val_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign root_o  = r_q[NS-1][tllik_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/tllik_cordic.sv =====
// tllik_cordic: two-lane vectoring cordic (normalize in three stages, then
// 20 rotation stages) giving atan2(v, u). Depends on tllik_pkg.
module tllik_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  tllik_pkg::cd_side_t               side_i,
  input  logic signed [tllik_pkg::CD_W-1:0] u_i [2],
  input  logic signed [tllik_pkg::CD_W-1:0] v_i [2],
  output logic                              valid_o,
  output tllik_pkg::cd_side_t               side_o,
  output logic signed [tllik_pkg::AN_W-1:0] ang_o [2]
);

  localparam int ST = tllik_pkg::CORDIC_STEPS;
  localparam int CW = tllik_pkg::CD_W;
  localparam int AW = tllik_pkg::AN_W;
  localparam int NM = tllik_pkg::NORM_MSB;

  // normalize stage 1: larger magnitude
  logic                n1_valid_q;
  tllik_pkg::cd_side_t n1_side_q;
  logic signed [CW-1:0] n1_u_q [2], n1_v_q [2];
  logic [CW-1:0]        n1_m_q [2], m_d [2], av [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      av[l]  = v_i[l][CW-1] ? CW'(-v_i[l]) : CW'(v_i[l]);
      m_d[l] = (CW'(u_i[l]) > av[l]) ? CW'(u_i[l]) : av[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_valid_q <= 1'b0;
    end else if (en_i) begin
      n1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_side_q <= side_i;
      n1_u_q    <= u_i;
      n1_v_q    <= v_i;
      n1_m_q    <= m_d;
    end
  end

  // normalize stage 2: shift amount from the leading one
  logic                n2_valid_q;
  tllik_pkg::cd_side_t n2_side_q;
  logic signed [CW-1:0] n2_u_q [2], n2_v_q [2];
  logic [tllik_pkg::SH_W-1:0] n2_sh_q [2], sh_d [2], msb [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      msb[l] = '0;
      for (int i = 0; i <= NM; i++) begin
        if (n1_m_q[l][i]) begin
          msb[l] = tllik_pkg::SH_W'(i);
        end
      end
      if ((|n1_m_q[l][CW-1:NM]) || (n1_m_q[l] == '0)) begin
        sh_d[l] = '0;
      end else begin
        sh_d[l] = tllik_pkg::SH_W'(NM) - msb[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n2_valid_q <= 1'b0;
    end else if (en_i) begin
      n2_valid_q <= n1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n2_side_q <= n1_side_q;
      n2_u_q    <= n1_u_q;
      n2_v_q    <= n1_v_q;
      n2_sh_q   <= sh_d;
    end
  end

  // normalize stage 3 feeds rotation entry 0
  logic                 val_q  [ST+1];
  tllik_pkg::cd_side_t  side_q [ST+1];
  logic signed [CW-1:0] cu_q   [ST+1][2];
  logic signed [CW-1:0] cv_q   [ST+1][2];
  logic signed [AW-1:0] ca_q   [ST+1][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q[0] <= 1'b0;
    end else if (en_i) begin
      val_q[0] <= n2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= n2_side_q;
      for (int l = 0; l < 2; l++) begin
        cu_q[0][l] <= n2_u_q[l] <<< n2_sh_q[l];
        cv_q[0][l] <= n2_v_q[l] <<< n2_sh_q[l];
        ca_q[0][l] <= '0;
      end
    end
  end

  // rotation stages, one micro-rotation each
  for (genvar k = 0; k < ST; k++) begin : g_step
    logic signed [CW-1:0] u_d [2], v_d [2];
    logic signed [AW-1:0] a_d [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (cv_q[k][l] > 0) begin
          u_d[l] = cu_q[k][l] + (cv_q[k][l] >>> k);
          v_d[l] = cv_q[k][l] - (cu_q[k][l] >>> k);
          a_d[l] = ca_q[k][l] + tllik_pkg::ATAN_TAB[k];
        end else begin
          u_d[l] = cu_q[k][l] - (cv_q[k][l] >>> k);
          v_d[l] = cv_q[k][l] + (cu_q[k][l] >>> k);
          a_d[l] = ca_q[k][l] - tllik_pkg::ATAN_TAB[k];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[k+1] <= 1'b0;
      end else if (en_i) begin
        val_q[k+1] <= val_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= side_q[k];
        cu_q[k+1]   <= u_d;
        cv_q[k+1]   <= v_d;
        ca_q[k+1]   <= a_d;
      end
    end
  end

  assign valid_o = val_q[ST];
  assign side_o  = side_q[ST];
  assign ang_o   = ca_q[ST];

endmodule

// ===== rtl/two_link_leg_inverse_kinematics_top.sv =====
// two_link_leg_inverse_kinematics_top: config registers, prep, square root,
// cordic and output stages of the leg solver. Depends on tllik_pkg and the
// tllik_prep, tllik_isqrt and tllik_cordic modules.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o   leg_index_i, foot_x_i, foot_z_i
//   out      output     out_valid_o/out_ready_i leg_tag_o, first/second_motor_angle_o,
//                                               ik_status_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item enters per cycle unless the output register is blocked. It passes through
// prep, square root, cordic, combine and output register stages; the 32-stage
// bit-serial root is the longest part. Reset clears valid bits and link lengths. When
// the output register holds a result that is not taken, the whole pipe holds in place.
module two_link_leg_inverse_kinematics_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tllik_pkg::LEG_W-1:0]         leg_index_i,
  input  logic signed [tllik_pkg::POS_W-1:0]  foot_x_i,
  input  logic signed [tllik_pkg::POS_W-1:0]  foot_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tllik_pkg::LEG_W-1:0]         leg_tag_o,
  output logic signed [tllik_pkg::ANG_W-1:0]  first_motor_angle_o,
  output logic signed [tllik_pkg::ANG_W-1:0]  second_motor_angle_o,
  output logic [tllik_pkg::STAT_W-1:0]        ik_status_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tllik_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tllik_pkg::LEN_W-1:0]         cfg_data_i
);

  localparam int CW = tllik_pkg::CD_W;
  localparam int SW = tllik_pkg::SUM_W;

  logic adv;
  logic out_valid_q;

  // whole pipe moves unless the output register is blocked
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // link length registers
  logic [tllik_pkg::LEN_W-1:0] upper_q, lower_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= '0;
      lower_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tllik_pkg::CFG_UPPER: upper_q <= cfg_data_i;
        tllik_pkg::CFG_LOWER: lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // squares and reach test
  logic                         pr_valid;
  tllik_pkg::sq_side_t          pr_side;
  logic [tllik_pkg::SQ_W-1:0]   pr_rem;

  tllik_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i && adv),
    .leg_i   (leg_index_i),
    .x_i     (foot_x_i),
    .z_i     (foot_z_i),
    .l1_i    (upper_q),
    .l2_i    (lower_q),
    .valid_o (pr_valid),
    .side_o  (pr_side),
    .rem_o   (pr_rem)
  );

  // sine side of the knee angle
  logic                         sq_valid;
  tllik_pkg::sq_side_t          sq_side;
  logic [tllik_pkg::ROOT_W-1:0] sq_root;

  tllik_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pr_valid),
    .side_i  (pr_side),
    .rem_i   (pr_rem),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  // lane 0 hip angle, lane 1 knee angle
  tllik_pkg::cd_side_t  cd_side_in;
  logic signed [CW-1:0] cd_u [2], cd_v [2];
  logic signed [CW-1:0] n_ext;

  assign n_ext = CW'(sq_side.n);

  always_comb begin
    cd_side_in.leg     = sq_side.leg;
    cd_side_in.degen   = sq_side.degen;
    cd_side_in.unreach = sq_side.unreach;
    cd_side_in.n_neg   = sq_side.n[tllik_pkg::N_W-1];
    cd_u[0] = $signed({{(CW-tllik_pkg::POS_W){1'b0}}, sq_side.gu});
    cd_v[0] = CW'(sq_side.gv);
    if (cd_side_in.n_neg) begin
      cd_u[1] = $signed({{(CW-tllik_pkg::ROOT_W){1'b0}}, sq_root});
      cd_v[1] = -n_ext;
    end else begin
      cd_u[1] = n_ext;
      cd_v[1] = $signed({{(CW-tllik_pkg::ROOT_W){1'b0}}, sq_root});
    end
  end

  logic                                cd_valid;
  tllik_pkg::cd_side_t                 cd_side;
  logic signed [tllik_pkg::AN_W-1:0]   cd_ang [2];

  tllik_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_valid),
    .side_i  (cd_side_in),
    .u_i     (cd_u),
    .v_i     (cd_v),
    .valid_o (cd_valid),
    .side_o  (cd_side),
    .ang_o   (cd_ang)
  );

  // knee term and motor angle sum and difference
  logic                 f1_valid_q;
  tllik_pkg::cd_side_t  f1_side_q;
  logic signed [SW-1:0] f1_first_q, f1_second_q;
  logic signed [SW-1:0] faai, gam;

  always_comb begin
    gam = SW'(cd_ang[0]);
    if (cd_side.unreach) begin
      faai = cd_side.n_neg ? SW'(tllik_pkg::PI_Q) : '0;
    end else if (cd_side.n_neg) begin
      faai = SW'(tllik_pkg::HALF_PI_Q) + SW'(cd_ang[1]);
    end else begin
      faai = SW'(cd_ang[1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= cd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_side_q   <= cd_side;
      f1_first_q  <= faai + gam;
      f1_second_q <= faai - gam;
    end
  end

  // output register: rounding, saturation, status
  logic [tllik_pkg::LEG_W-1:0]         out_leg_q;
  logic signed [tllik_pkg::ANG_W-1:0]  out_first_q, out_second_q;
  tllik_pkg::status_e                  out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_leg_q <= f1_side_q.leg;
      if (f1_side_q.degen) begin
        out_first_q  <= '0;
        out_second_q <= '0;
        out_status_q <= tllik_pkg::ST_DEGEN;
      end else begin
        out_first_q  <= tllik_pkg::angle_round(f1_first_q);
        out_second_q <= tllik_pkg::angle_round(f1_second_q);
        out_status_q <= f1_side_q.unreach ? tllik_pkg::ST_UNREACH : tllik_pkg::ST_OK;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign leg_tag_o            = out_leg_q;
  assign first_motor_angle_o  = out_first_q;
  assign second_motor_angle_o = out_second_q;
  assign ik_status_o          = out_status_q;

  // degenerate results carry zero angles
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ik_status_o == tllik_pkg::ST_DEGEN)
    |-> (first_motor_angle_o == '0) && (second_motor_angle_o == '0))
    else $error("degenerate result with nonzero angle");

  // a blocked result stays in the output register
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_first_q))
    else $error("blocked result lost");

  // input is refused while the output is blocked
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted during stall");

endmodule
